// ===== src/q2e_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle core.
// Used by every module in src; depends on nothing.
`timescale 1ns / 1ps
package q2e_pkg;

	localparam int AngTabLen = 24;
	localparam int AngW = 32;
	localparam int CordW = 40;
	localparam int SqW = 34;

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	typedef struct packed {
		logic signed [CordW-1:0] yaw_y;
		logic signed [CordW-1:0] yaw_x;
		logic signed [CordW-1:0] roll_y;
		logic signed [CordW-1:0] roll_x;
		logic signed [CordW-1:0] pitch_y;
		logic [SqW-1:0]          pitch_rad;
		logic                    norm_zero;
		pole_t                   pole;
	} cls_t;

	function automatic logic signed [AngW-1:0] ang_tab(input int i);
		logic signed [AngW-1:0] r;
		begin
			r = '0;
			case (i)
				0: r = 32'sd294912000;
				1: r = 32'sd174096719;
				2: r = 32'sd91987925;
				3: r = 32'sd46694507;
				4: r = 32'sd23437865;
				5: r = 32'sd11730358;
				6: r = 32'sd5866610;
				7: r = 32'sd2933484;
				8: r = 32'sd1466764;
				9: r = 32'sd733385;
				10: r = 32'sd366693;
				11: r = 32'sd183346;
				12: r = 32'sd91673;
				13: r = 32'sd45837;
				14: r = 32'sd22918;
				15: r = 32'sd11459;
				16: r = 32'sd5730;
				17: r = 32'sd2865;
				18: r = 32'sd1432;
				19: r = 32'sd716;
				20: r = 32'sd358;
				21: r = 32'sd179;
				22: r = 32'sd90;
				23: r = 32'sd45;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== src/q2e_front.sv =====
// Front end: products, norm, pole classification, square root and CORDIC operand setup.
// Depends on q2e_pkg. All stages advance together while enabled.
`timescale 1ns / 1ps
module q2e_front import q2e_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [15:0]  quat_x,
	input  logic signed [15:0]  quat_y,
	input  logic signed [15:0]  quat_z,
	input  logic signed [15:0]  quat_w,
	input  logic [15:0]         pole_threshold,
	output logic                out_valid,
	output cls_t                out_cls
);
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, wz_s1, yw_s1, xz_s1, xw_s1, yz_s1;
	logic signed [15:0] x_s1, w_s1;
	logic [15:0] thr_s1;
	logic v_s1, v_s2;
	cls_t cls_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			ww_s1 <= quat_w * quat_w;
			xy_s1 <= quat_x * quat_y;
			wz_s1 <= quat_w * quat_z;
			yw_s1 <= quat_y * quat_w;
			xz_s1 <= quat_x * quat_z;
			xw_s1 <= quat_x * quat_w;
			yz_s1 <= quat_y * quat_z;
			x_s1 <= quat_x;
			w_s1 <= quat_w;
			thr_s1 <= pole_threshold;
		end
	end

	logic signed [33:0] n, t, p, q;
	logic signed [51:0] lim, t_sh;
	logic [31:0] pq4, qq4;
	logic [31:0] pq_hi, pq_lo;
	cls_t c;
	always_comb begin
		n = 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1) + 34'(ww_s1);
		t = 34'(xy_s1) + 34'(wz_s1);
		lim = 52'(n) * $signed({1'b0, thr_s1});
		t_sh = 52'(t) <<< 16;
		p = n - (t <<< 1);
		q = n + (t <<< 1);
		pq4 = p[33] ? '0 : 32'(p >>> 2);
		qq4 = q[33] ? '0 : 32'(q >>> 2);
		c = '0;
		if (t_sh > lim) c.pole = POLE_NORTH;
		else if (t_sh < -lim) c.pole = POLE_SOUTH;
		else c.pole = POLE_NONE;
		if (c.pole != POLE_NONE) begin
			c.yaw_y = CordW'(x_s1);
			c.yaw_x = CordW'(w_s1);
		end else begin
			c.yaw_y = (CordW'(yw_s1) - CordW'(xz_s1)) <<< 1;
			c.yaw_x = CordW'(xx_s1) - CordW'(yy_s1) - CordW'(zz_s1) + CordW'(ww_s1);
		end
		c.roll_y = (CordW'(xw_s1) - CordW'(yz_s1)) <<< 1;
		c.roll_x = -CordW'(xx_s1) + CordW'(yy_s1) - CordW'(zz_s1) + CordW'(ww_s1);
		c.pitch_y = CordW'(t >>> 1);
		c.norm_zero = (n == '0);
		// product taken in the stage-2 register ahead of the sqrt; here its two factors are set up
		c.pitch_rad = '0;
		pq_hi = pq4;
		pq_lo = qq4;
	end

	logic [63:0] rad_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s2 <= c;
			rad_s2 <= 64'(pq_hi) * 64'(pq_lo);
		end
	end

	// isqrt of the 64-bit radicand, one result bit per stage
	localparam int SqSteps = 32;
	logic [63:0] rem_r [SqSteps+1];
	logic [31:0] res_r [SqSteps+1];
	logic        vld_r [SqSteps+1];
	cls_t        cls_r [SqSteps+1];
	always_comb begin
		rem_r[0] = rad_s2;
		res_r[0] = '0;
		vld_r[0] = v_s2;
		cls_r[0] = cls_s2;
	end
	for (genvar k = 0; k < SqSteps; k++) begin : g_sq
		logic [65:0] trial;
		logic [63:0] rem_n;
		logic [31:0] res_n;
		always_comb begin
			trial = {2'b0, rem_r[k]} - ({34'(res_r[k]), 2'b01} << (2 * (SqSteps - 1 - k)));
			if (!trial[65]) begin
				rem_n = trial[63:0];
				res_n = {res_r[k][30:0], 1'b1};
			end else begin
				rem_n = rem_r[k];
				res_n = {res_r[k][30:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_r[k+1] <= 1'b0;
			else if (en) vld_r[k+1] <= vld_r[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[k+1] <= rem_n;
				res_r[k+1] <= res_n;
				cls_r[k+1] <= cls_r[k];
			end
		end
	end

	always_comb begin
		out_cls = cls_r[SqSteps];
		out_cls.pitch_rad = SqW'(res_r[SqSteps]);
	end
	assign out_valid = vld_r[SqSteps];
endmodule

// ===== src/q2e_back.sv =====
// Back end: three pipelined CORDIC vectoring units and final rounding.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
module q2e_back import q2e_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  cls_t               in_cls,
	output logic               out_valid,
	output logic signed [16:0] yaw_centideg,
	output logic signed [14:0] pitch_centideg,
	output logic signed [15:0] roll_centideg,
	output pole_t              pole_case
);
	localparam int NSt = (CORDIC_STAGES < AngTabLen) ? CORDIC_STAGES : AngTabLen;

	logic signed [CordW-1:0] ax [3][NSt+1];
	logic signed [CordW-1:0] ay [3][NSt+1];
	logic signed [AngW+1:0]  az [3][NSt+1];
	logic                    zr [3][NSt+1];
	logic                    vv [NSt+1];
	cls_t                    cc [NSt+1];

	logic signed [CordW-1:0] ix [3], iy [3];
	always_comb begin
		iy[0] = in_cls.yaw_y;   ix[0] = in_cls.yaw_x;
		iy[1] = in_cls.pitch_y; ix[1] = CordW'(in_cls.pitch_rad);
		iy[2] = in_cls.roll_y;  ix[2] = in_cls.roll_x;
	end

	for (genvar u = 0; u < 3; u++) begin : g_fold
		always_comb begin
			zr[u][0] = (ix[u] == '0) && (iy[u] == '0);
			if (ix[u] < 0) begin
				if (iy[u] >= 0) begin
					az[u][0] = (AngW+2)'(ang_tab(0)) <<< 1;
					ax[u][0] = iy[u]; ay[u][0] = -ix[u];
				end else begin
					az[u][0] = -((AngW+2)'(ang_tab(0)) <<< 1);
					ax[u][0] = -iy[u]; ay[u][0] = ix[u];
				end
			end else begin
				az[u][0] = '0; ax[u][0] = ix[u]; ay[u][0] = iy[u];
			end
		end
	end
	assign vv[0] = in_valid;
	assign cc[0] = in_cls;

	for (genvar i = 0; i < NSt; i++) begin : g_st
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vv[i+1] <= 1'b0;
			else if (en) vv[i+1] <= vv[i];
		end
		always_ff @(posedge clk) begin
			if (en) cc[i+1] <= cc[i];
		end
		for (genvar u = 0; u < 3; u++) begin : g_u
			always_ff @(posedge clk) begin
				if (en) begin
					zr[u][i+1] <= zr[u][i];
					if (ay[u][i] >= 0) begin
						ax[u][i+1] <= ax[u][i] + (ay[u][i] >>> i);
						ay[u][i+1] <= ay[u][i] - (ax[u][i] >>> i);
						az[u][i+1] <= az[u][i] + (AngW+2)'(ang_tab(i));
					end else begin
						ax[u][i+1] <= ax[u][i] - (ay[u][i] >>> i);
						ay[u][i+1] <= ay[u][i] + (ax[u][i] >>> i);
						az[u][i+1] <= az[u][i] - (AngW+2)'(ang_tab(i));
					end
				end
			end
		end
	end

	logic signed [AngW+1:0] rz [3];
	logic signed [17:0] ang [3];
	for (genvar u = 0; u < 3; u++) begin : g_rnd
		always_comb begin
			rz[u] = az[u][NSt] + (AngW+2)'(32768);
			ang[u] = zr[u][NSt] ? '0 : 18'(rz[u] >>> 16);
		end
	end

	cls_t cf;
	logic signed [17:0] yaw_n, pitch_n, roll_n;
	always_comb begin
		cf = cc[NSt];
		unique case (cf.pole)
			POLE_NORTH: begin
				yaw_n = ang[0] <<< 1; pitch_n = 18'sd9000; roll_n = '0;
			end
			POLE_SOUTH: begin
				yaw_n = -(ang[0] <<< 1); pitch_n = -18'sd9000; roll_n = '0;
			end
			default: begin
				yaw_n = (ang[0] > 18000) ? 18'sd18000 :
				        (ang[0] < -18000) ? -18'sd18000 : ang[0];
				roll_n = (ang[2] > 18000) ? 18'sd18000 :
				         (ang[2] < -18000) ? -18'sd18000 : ang[2];
				pitch_n = cf.norm_zero ? '0 :
				          (ang[1] > 9000) ? 18'sd9000 :
				          (ang[1] < -9000) ? -18'sd9000 : ang[1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vv[NSt];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			yaw_centideg <= 17'(yaw_n);
			pitch_centideg <= 15'(pitch_n);
			roll_centideg <= 16'(roll_n);
			pole_case <= cf.pole;
		end
	end
endmodule

// ===== src/q2e_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on q2e_pkg; lets front and back stall on their own.
`timescale 1ns / 1ps
module q2e_queue import q2e_pkg::*; #(
	parameter int DEPTH = 4,
	parameter int W = 50
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
		end
	end
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign count = cnt_q;
endmodule

// ===== src/quaternion_to_euler_degrees_core.sv =====
// Quaternion to Euler angle core, top level.
// Depends on q2e_pkg, q2e_front, q2e_back and q2e_queue.
`timescale 1ns / 1ps
// One quaternion per cycle is accepted and one result leaves per cycle while nothing
// holds; CORDIC_STAGES is capped at 24. The path runs through products, norm, 32-step
// square root, queue, CORDIC and rounding. The back end holds while a result waits
// on m_axis_tready; the front end holds, dropping s_axis_tready, only while its
// finished item finds the four-entry queue between them full.
module quaternion_to_euler_degrees_core import q2e_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // yaw, pitch, roll
	output logic [1:0]  m_axis_tuser    // pole_case
);
	localparam int QDepth = 4;

	logic [15:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= 16'd32702;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	logic [$clog2(QDepth+1)-1:0] qcnt;
	logic en_f, en_b, fv, qv, qfull, rd;
	cls_t fc, qc;
	logic signed [16:0] yaw;
	logic signed [14:0] pitch;
	logic signed [15:0] roll;
	pole_t pole;

	assign qfull = 32'(qcnt) == 32'(QDepth);
	assign en_f = !(fv && qfull);
	assign s_axis_tready = en_f;
	assign en_b = !m_axis_tvalid || m_axis_tready;
	assign rd = en_b && qv;

	q2e_front u_front (
		.clk, .arst_n, .en(en_f), .in_valid(s_axis_tvalid),
		.quat_x(s_axis_tdata[15:0]), .quat_y(s_axis_tdata[31:16]),
		.quat_z(s_axis_tdata[47:32]), .quat_w(s_axis_tdata[63:48]),
		.pole_threshold(thr_q), .out_valid(fv), .out_cls(fc)
	);

	q2e_queue #(.DEPTH(QDepth), .W($bits(cls_t))) u_queue (
		.clk, .arst_n, .wr_en(fv && !qfull), .wr_data(fc),
		.rd_valid(qv), .rd_en(rd), .rd_data(qc), .count(qcnt)
	);

	q2e_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk, .arst_n, .en(en_b), .in_valid(qv), .in_cls(qc), .out_valid(m_axis_tvalid),
		.yaw_centideg(yaw), .pitch_centideg(pitch), .roll_centideg(roll),
		.pole_case(pole)
	);

	assign m_axis_tdata = {roll, pitch, yaw};
	assign m_axis_tuser = pole;

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		32'(qcnt) <= 32'(QDepth)) else $error("queue overflow");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en_f |-> !s_axis_tready) else $error("accepted while stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser)) else $error("output changed while waiting");
endmodule
